### hw/rtl/nrp95_pkg.sv
`timescale 1ns / 1ps

package nrp95_pkg;

    // Buffer geometry.
    localparam int MAX_SAMPLES = 4096;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    // Sample and result field widths.
    localparam int VAL_W     = 32;
    localparam int BIT_W     = $clog2(VAL_W);
    localparam int OUT_CNT_W = 13;

    // Nearest rank: r = (n * PCT_NUM + PCT_ROUND) / PCT_DEN.
    localparam int PCT_NUM   = 95;
    localparam int PCT_ROUND = 99;
    localparam int PCT_DEN   = 100;

    // The division by PCT_DEN is a multiply by a rounded-up reciprocal.
    // With a shift of the numerator width plus the divisor width, the
    // quotient is exact for every numerator that fits RANK_X_W bits.
    localparam int RANK_X_W = $clog2(MAX_SAMPLES * PCT_NUM + PCT_ROUND + 1);
    localparam int DEN_W    = $clog2(PCT_DEN);
    localparam int RECIP_SH = RANK_X_W + DEN_W;
    localparam longint RECIP_M = ((longint'(1) << RECIP_SH) + PCT_DEN - 1) / PCT_DEN;
    localparam int RECIP_W  = RECIP_SH - DEN_W + 1;
    localparam int PROD_W   = RANK_X_W + RECIP_W;

    // Job queue between the loader and the selection engine.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One buffer write from the loader.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  data;
    } mem_wr_t;

    // One finished set waiting for selection.
    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic             ovf;
    } job_t;

    // Selection engine states.
    typedef enum logic [2:0] {
        B_IDLE,
        B_RANK,
        B_SCAN,
        B_DRAIN,
        B_DECIDE,
        B_HOLD
    } back_state_t;

endpackage

### hw/rtl/nrp95_front.sv
`timescale 1ns / 1ps

module nrp95_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [nrp95_pkg::VAL_W-1:0]          sample,
    input  logic                                 last,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 back_busy,
    input  logic                                 q_empty,
    output nrp95_pkg::mem_wr_t                   mem_wr,
    output logic                                 q_push,
    output nrp95_pkg::job_t                      q_job
);

    logic [nrp95_pkg::CNT_W-1:0] fill_count_reg;
    logic [nrp95_pkg::CNT_W-1:0] fill_count_next;
    logic                        ovf_reg;
    logic                        ovf_next;
    logic                        accept;
    logic                        room;
    logic [nrp95_pkg::CNT_W-1:0] n_after;
    logic                        ovf_after;

    // The buffer belongs to the selection engine while a set is queued or walked.
    assign in_stall = back_busy || !q_empty;
    assign accept   = in_valid && !in_stall;

    // A sample is kept while the buffer has room, otherwise it is dropped.
    assign room      = fill_count_reg < nrp95_pkg::CNT_W'(nrp95_pkg::MAX_SAMPLES);
    assign n_after   = room ? fill_count_reg + 1'b1 : fill_count_reg;
    assign ovf_after = ovf_reg || !room;

    // Buffer write for a kept sample.
    always_comb
    begin
        mem_wr.en   = accept && room;
        mem_wr.addr = fill_count_reg[nrp95_pkg::ADDR_W-1:0];
        mem_wr.data = sample;
    end

    // The item marked last closes the set and hands it to the engine.
    assign q_push    = accept && last;
    assign q_job.n   = n_after;
    assign q_job.ovf = ovf_after;

    // Fill count and overflow flag for the open set.
    always_comb
    begin
        fill_count_next = fill_count_reg;
        ovf_next        = ovf_reg;
        if (accept)
        begin
            if (last)
            begin
                fill_count_next = '0;
                ovf_next        = 1'b0;
            end
            else
            begin
                fill_count_next = n_after;
                ovf_next        = ovf_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            ovf_reg        <= ovf_next;
        end
    end

endmodule

### hw/rtl/nrp95_queue.sv
`timescale 1ns / 1ps

module nrp95_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  nrp95_pkg::job_t push_job,
    input  logic            pop,
    output nrp95_pkg::job_t head_job,
    output logic            empty,
    output logic            full
);

    nrp95_pkg::job_t              entry_reg [nrp95_pkg::QUEUE_DEPTH];
    logic [nrp95_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [nrp95_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [nrp95_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [nrp95_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [nrp95_pkg::QCNT_W-1:0] count_reg;
    logic [nrp95_pkg::QCNT_W-1:0] count_next;
    logic                         do_push;
    logic                         do_pop;

    assign empty    = count_reg == '0;
    assign full     = count_reg == nrp95_pkg::QCNT_W'(nrp95_pkg::QUEUE_DEPTH);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### hw/rtl/nrp95_back.sv
`timescale 1ns / 1ps

module nrp95_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  nrp95_pkg::mem_wr_t                mem_wr,
    input  logic                              q_empty,
    input  nrp95_pkg::job_t                   q_job,
    output logic                              q_pop,
    output logic                              back_busy,
    output logic [nrp95_pkg::VAL_W-1:0]       percentile_value,
    output logic [nrp95_pkg::OUT_CNT_W-1:0]   sample_count,
    output logic                              overflowed,
    output logic                              out_valid,
    input  logic                              out_stall
);

    // Sample buffer: one write port from the loader, one registered read port.
    logic [nrp95_pkg::VAL_W-1:0] sample_mem [nrp95_pkg::MAX_SAMPLES];

    nrp95_pkg::back_state_t state_reg;
    nrp95_pkg::back_state_t state_next;

    logic [nrp95_pkg::CNT_W-1:0]    n_reg;
    logic [nrp95_pkg::CNT_W-1:0]    n_next;
    logic                           ovf_reg;
    logic                           ovf_next;
    logic [nrp95_pkg::RANK_X_W-1:0] x_reg;
    logic [nrp95_pkg::RANK_X_W-1:0] x_next;
    logic [nrp95_pkg::CNT_W-1:0]    r_reg;
    logic [nrp95_pkg::CNT_W-1:0]    r_next;
    logic [nrp95_pkg::VAL_W-1:0]    res_reg;
    logic [nrp95_pkg::VAL_W-1:0]    res_next;
    logic [nrp95_pkg::BIT_W-1:0]    bit_reg;
    logic [nrp95_pkg::BIT_W-1:0]    bit_next;
    logic [nrp95_pkg::CNT_W-1:0]    scan_idx_reg;
    logic [nrp95_pkg::CNT_W-1:0]    scan_idx_next;
    logic [nrp95_pkg::CNT_W-1:0]    cnt_reg;
    logic [nrp95_pkg::CNT_W-1:0]    cnt_next;
    logic                           rd_valid_reg;
    logic                           rd_valid_next;
    logic [nrp95_pkg::VAL_W-1:0]    rd_data_reg;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [nrp95_pkg::VAL_W-1:0]       out_value_reg;
    logic [nrp95_pkg::OUT_CNT_W-1:0]   out_count_reg;
    logic                              out_ovf_reg;
    logic                              out_load;

    logic [nrp95_pkg::PROD_W-1:0]   rank_prod;
    logic [nrp95_pkg::CNT_W-1:0]    rank_q;
    logic [nrp95_pkg::VAL_W-1:0]    test_value;
    logic [nrp95_pkg::VAL_W-1:0]    bit_mask;
    logic                           hit;
    logic                           scan_last;
    logic                           out_free;

    // Rank quotient by reciprocal multiply; exact for every numerator.
    assign rank_prod = nrp95_pkg::PROD_W'(x_reg)
                     * nrp95_pkg::PROD_W'(nrp95_pkg::RECIP_M);
    assign rank_q    = nrp95_pkg::CNT_W'(rank_prod >> nrp95_pkg::RECIP_SH);

    // Candidate for the current bit: bits above fixed, this bit zero, lower bits one.
    assign bit_mask   = nrp95_pkg::VAL_W'(1) << bit_reg;
    assign test_value = res_reg | (bit_mask - 1'b1);
    assign hit        = rd_valid_reg && (rd_data_reg <= test_value);
    assign scan_last  = (scan_idx_reg + 1'b1) == n_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    assign back_busy = (state_reg == nrp95_pkg::B_RANK)
                    || (state_reg == nrp95_pkg::B_SCAN)
                    || (state_reg == nrp95_pkg::B_DRAIN)
                    || (state_reg == nrp95_pkg::B_DECIDE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nrp95_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = nrp95_pkg::B_RANK;
                end
            end
            nrp95_pkg::B_RANK:
            begin
                state_next = nrp95_pkg::B_SCAN;
            end
            nrp95_pkg::B_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = nrp95_pkg::B_DRAIN;
                end
            end
            nrp95_pkg::B_DRAIN:
            begin
                state_next = nrp95_pkg::B_DECIDE;
            end
            nrp95_pkg::B_DECIDE:
            begin
                if (bit_reg == '0)
                begin
                    state_next = nrp95_pkg::B_HOLD;
                end
                else
                begin
                    state_next = nrp95_pkg::B_SCAN;
                end
            end
            nrp95_pkg::B_HOLD:
            begin
                if (out_free)
                begin
                    state_next = nrp95_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = nrp95_pkg::B_IDLE;
            end
        endcase
    end

    // Datapath controls per state.
    always_comb
    begin
        q_pop         = 1'b0;
        out_load      = 1'b0;
        n_next        = n_reg;
        ovf_next      = ovf_reg;
        x_next        = x_reg;
        r_next        = r_reg;
        res_next      = res_reg;
        bit_next      = bit_reg;
        scan_idx_next = scan_idx_reg;
        cnt_next      = cnt_reg + nrp95_pkg::CNT_W'(hit);
        rd_valid_next = state_reg == nrp95_pkg::B_SCAN;
        case (state_reg)
            nrp95_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    n_next   = q_job.n;
                    ovf_next = q_job.ovf;
                    x_next   = nrp95_pkg::RANK_X_W'(q_job.n)
                             * nrp95_pkg::RANK_X_W'(nrp95_pkg::PCT_NUM)
                             + nrp95_pkg::RANK_X_W'(nrp95_pkg::PCT_ROUND);
                end
            end
            nrp95_pkg::B_RANK:
            begin
                // Clamp the rank into 1..n.
                if (rank_q == '0)
                begin
                    r_next = nrp95_pkg::CNT_W'(1);
                end
                else if (rank_q > n_reg)
                begin
                    r_next = n_reg;
                end
                else
                begin
                    r_next = rank_q;
                end
                res_next      = '0;
                bit_next      = nrp95_pkg::BIT_W'(nrp95_pkg::VAL_W - 1);
                scan_idx_next = '0;
                cnt_next      = '0;
            end
            nrp95_pkg::B_SCAN:
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
            end
            nrp95_pkg::B_DRAIN:
            begin
                scan_idx_next = '0;
            end
            nrp95_pkg::B_DECIDE:
            begin
                // Too few samples at or below the candidate: this bit is one.
                if (cnt_reg < r_reg)
                begin
                    res_next = res_reg | bit_mask;
                end
                if (bit_reg != '0)
                begin
                    bit_next = bit_reg - 1'b1;
                end
                scan_idx_next = '0;
                cnt_next      = '0;
            end
            nrp95_pkg::B_HOLD:
            begin
                out_load = out_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Output register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nrp95_pkg::B_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers of the selection walk.
    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        ovf_reg      <= ovf_next;
        x_reg        <= x_next;
        r_reg        <= r_next;
        res_reg      <= res_next;
        bit_reg      <= bit_next;
        scan_idx_reg <= scan_idx_next;
        cnt_reg      <= cnt_next;
        if (out_load)
        begin
            out_value_reg <= res_reg;
            out_count_reg <= nrp95_pkg::OUT_CNT_W'(n_reg);
            out_ovf_reg   <= ovf_reg;
        end
    end

    // Buffer write and registered read.
    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            sample_mem[mem_wr.addr] <= mem_wr.data;
        end
        rd_data_reg <= sample_mem[scan_idx_reg[nrp95_pkg::ADDR_W-1:0]];
    end

    assign out_valid        = out_valid_reg;
    assign percentile_value = out_value_reg;
    assign sample_count     = out_count_reg;
    assign overflowed       = out_ovf_reg;

endmodule

### hw/rtl/nearest_rank_p95_select.sv
`timescale 1ns / 1ps

// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------------
// input    | in_valid / in_stall  | sample[31:0], last
// output   | out_valid / out_stall| percentile_value[31:0], sample_count[12:0], overflowed
//
// Samples load at one item per cycle, while in_stall is low, into a 4096-entry buffer.
// After the item marked last, input stalls while the engine walks the buffer once
// per result bit with its single read port.
// A finished result waits in the output register; loading of the next set resumes
// as soon as the walk ends, even while out_stall holds the result.
// Reset clears the fill count, flags and handshake state; the buffer is not cleared.

module nearest_rank_p95_select
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [nrp95_pkg::VAL_W-1:0]         sample,
    input  logic                                last,
    input  logic                                in_valid,
    output logic                                in_stall,
    output logic [nrp95_pkg::VAL_W-1:0]         percentile_value,
    output logic [nrp95_pkg::OUT_CNT_W-1:0]     sample_count,
    output logic                                overflowed,
    output logic                                out_valid,
    input  logic                                out_stall
);

    nrp95_pkg::mem_wr_t mem_wr;
    nrp95_pkg::job_t    push_job;
    nrp95_pkg::job_t    head_job;
    logic               q_push;
    logic               q_pop;
    logic               q_empty;
    logic               q_full;
    logic               back_busy;

    // Loader: keeps the fill count and closes each set.
    nrp95_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .last      (last),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .back_busy (back_busy),
        .q_empty   (q_empty),
        .mem_wr    (mem_wr),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    // Closed sets waiting for selection.
    nrp95_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    // Selection engine with the sample buffer and the output register.
    nrp95_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .mem_wr           (mem_wr),
        .q_empty          (q_empty),
        .q_job            (head_job),
        .q_pop            (q_pop),
        .back_busy        (back_busy),
        .percentile_value (percentile_value),
        .sample_count     (sample_count),
        .overflowed       (overflowed),
        .out_valid        (out_valid),
        .out_stall        (out_stall)
    );

    // No sample may land in the buffer while the engine walks it.
    assert property (@(posedge clk) disable iff (!rst_n)
        back_busy |-> in_stall)
        else $error("input accepted during selection walk");

    // Closing a set blocks input until the engine has taken it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last) |=> in_stall)
        else $error("input not stalled after last item");

    // The job queue never receives a set while full.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job queue overflow");

    // A delivered result always covers at least one kept sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sample_count != '0))
        else $error("result with empty sample count");

endmodule
